/* rtl/core/lmcf_pkg.sv */
// Shared types and constants of the LED matrix chain command framer.
// Used by every module under rtl/core; depends on nothing.
package lmcf_pkg;

   // Field widths
   localparam int KIND_W  = 3;
   localparam int DEV_W   = 3;
   localparam int ROW_W   = 3;
   localparam int COL_W   = 3;
   localparam int VAL_W   = 8;
   localparam int OPC_W   = 4;
   localparam int WORD_W  = 16;
   localparam int CNT_W   = 4;

   // Geometry
   localparam int ROWS            = 8;
   localparam int MAX_DEVICES_DEF = 8;
   localparam int QUEUE_DEPTH     = 2;

   // Register port
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;
   localparam logic [CNT_W-1:0] COUNT_RESET = 4'd8;
   localparam logic REG_DEVICE_COUNT = 1'b0;

   // Controller register opcodes and limits
   localparam logic [OPC_W-1:0] OPC_INTENSITY = 4'd10;
   localparam logic [OPC_W-1:0] OPC_SCANLIMIT = 4'd11;
   localparam logic [OPC_W-1:0] OPC_SHUTDOWN  = 4'd12;
   localparam logic [VAL_W-1:0] INTENSITY_MAX = 8'd15;
   localparam logic [VAL_W-1:0] SCANLIMIT_MAX = 8'd7;
   localparam logic [VAL_W-1:0] COLUMN_MSB    = 8'h80;

   typedef enum logic [KIND_W-1:0] {
      KIND_LED,
      KIND_ROW,
      KIND_COLUMN,
      KIND_CLEAR,
      KIND_SHUTDOWN,
      KIND_INTENSITY,
      KIND_SCANLIMIT,
      KIND_RAW
   } kind_type;

   // Work for the back end
   typedef enum logic [2:0] {
      JOB_LED,
      JOB_ROW,
      JOB_COLUMN,
      JOB_CLEAR,
      JOB_REG
   } job_op_type;

   typedef struct packed {
      job_op_type       op;
      logic [DEV_W-1:0] device;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] column;
      logic [VAL_W-1:0] value;
      logic [OPC_W-1:0] reg_opc;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* rtl/core/lmcf_front.sv */
// Front end: takes commands, drops the ones that do nothing and turns the
// rest into jobs for the queue. Depends on lmcf_pkg.
module lmcf_front (
   input  logic [lmcf_pkg::KIND_W-1:0] req_kind,
   input  logic [lmcf_pkg::DEV_W-1:0]  req_device,
   input  logic [lmcf_pkg::ROW_W-1:0]  req_row,
   input  logic [lmcf_pkg::COL_W-1:0]  req_column,
   input  logic [lmcf_pkg::VAL_W-1:0]  req_value,
   input  logic [lmcf_pkg::OPC_W-1:0]  req_opcode,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [lmcf_pkg::CNT_W-1:0]  eff_count,
   input  lmcf_pkg::queue_status_type  q_status,
   output logic                        push,
   output lmcf_pkg::job_type           job
);

   logic keep;
   logic in_chain;

   // Stall only while the queue has no room
   assign req_stall = q_status.full;
   assign in_chain  = {1'b0, req_device} < eff_count;

   // Classify the command
   always_comb begin
      job.device  = req_device;
      job.row     = req_row;
      job.column  = req_column;
      job.value   = req_value;
      job.reg_opc = req_opcode;
      job.op      = lmcf_pkg::JOB_REG;
      keep        = in_chain;
      unique case (lmcf_pkg::kind_type'(req_kind))
         lmcf_pkg::KIND_LED:    job.op = lmcf_pkg::JOB_LED;
         lmcf_pkg::KIND_ROW:    job.op = lmcf_pkg::JOB_ROW;
         lmcf_pkg::KIND_COLUMN: job.op = lmcf_pkg::JOB_COLUMN;
         lmcf_pkg::KIND_CLEAR:  job.op = lmcf_pkg::JOB_CLEAR;
         lmcf_pkg::KIND_SHUTDOWN: begin
            job.reg_opc = lmcf_pkg::OPC_SHUTDOWN;
            job.value   = (req_value != '0) ? 8'd0 : 8'd1;
         end
         lmcf_pkg::KIND_INTENSITY: begin
            job.reg_opc = lmcf_pkg::OPC_INTENSITY;
            keep        = in_chain && (req_value <= lmcf_pkg::INTENSITY_MAX);
         end
         lmcf_pkg::KIND_SCANLIMIT: begin
            job.reg_opc = lmcf_pkg::OPC_SCANLIMIT;
            keep        = in_chain && (req_value <= lmcf_pkg::SCANLIMIT_MAX);
         end
         default: job.op = lmcf_pkg::JOB_REG;
      endcase
   end

   // Drop ignored commands at acceptance
   assign push = req_valid && !q_status.full && keep;

endmodule

/* rtl/core/lmcf_queue.sv */
// Short job queue between front and back end.
// Depends on lmcf_pkg.
module lmcf_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  lmcf_pkg::job_type          push_job,
   input  logic                       pop,
   output lmcf_pkg::job_type          head_job,
   output lmcf_pkg::queue_status_type status
);

   localparam int PTR_W = (lmcf_pkg::QUEUE_DEPTH > 1) ? $clog2(lmcf_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(lmcf_pkg::QUEUE_DEPTH + 1);

   lmcf_pkg::job_type entry_ff [lmcf_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(lmcf_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_job     = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(lmcf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(lmcf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* rtl/core/lmcf_back.sv */
// Back end: keeps the row shadow memory, updates it per job and sends the
// frames word by word through an output register. Depends on lmcf_pkg.
module lmcf_back #(
   parameter int MAX_DEVICES = lmcf_pkg::MAX_DEVICES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [lmcf_pkg::CNT_W-1:0]  eff_count,
   input  lmcf_pkg::queue_status_type  q_status,
   input  lmcf_pkg::job_type           head_job,
   output logic                        pop,
   output logic [lmcf_pkg::WORD_W-1:0] rsp_word,
   output logic                        rsp_end_of_frame,
   output logic                        rsp_last,
   output logic                        rsp_valid,
   input  logic                        rsp_stall
);

   localparam int DEPTH  = MAX_DEVICES * lmcf_pkg::ROWS;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_MODIFY,
      ST_EMIT
   } state_type;

   state_type state_ff;
   lmcf_pkg::job_type job_ff;
   logic [lmcf_pkg::ROW_W-1:0] row_ff;
   logic [lmcf_pkg::DEV_W-1:0] idx_ff;
   logic [lmcf_pkg::OPC_W-1:0] opc_ff, opc_in;
   logic [lmcf_pkg::VAL_W-1:0] data_ff, data_in;
   logic [lmcf_pkg::WORD_W-1:0] word_ff;
   logic eof_ff, last_ff, valid_out_ff;

   logic [lmcf_pkg::VAL_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0] row_valid_ff;
   logic [lmcf_pkg::VAL_W-1:0] rd_data_ff;

   logic [ADDR_W-1:0] addr;
   logic [lmcf_pkg::VAL_W-1:0] cur_byte, new_byte, bit_mask;
   logic led_on, wr_en, out_free, multi, final_frame;
   logic [lmcf_pkg::ROW_W-1:0] bit_sel;

   assign addr     = ADDR_W'({job_ff.device, row_ff});
   assign cur_byte = row_valid_ff[addr] ? rd_data_ff : '0;
   assign bit_mask = lmcf_pkg::COLUMN_MSB >> job_ff.column;
   assign bit_sel  = 3'd7 - row_ff;
   assign multi    = (job_ff.op == lmcf_pkg::JOB_COLUMN) || (job_ff.op == lmcf_pkg::JOB_CLEAR);
   assign final_frame = !multi || (row_ff == 3'd7);
   assign out_free = !valid_out_ff || !rsp_stall;
   assign pop      = (state_ff == ST_IDLE) && !q_status.empty;

   // Work out the new row byte and the frame's opcode and data
   always_comb begin
      led_on   = (job_ff.op == lmcf_pkg::JOB_LED) ? (job_ff.value != '0)
                                                  : job_ff.value[bit_sel];
      new_byte = cur_byte;
      opc_in   = {1'b0, row_ff} + 4'd1;
      wr_en    = 1'b0;
      unique case (job_ff.op)
         lmcf_pkg::JOB_LED, lmcf_pkg::JOB_COLUMN: begin
            new_byte = led_on ? (cur_byte | bit_mask) : (cur_byte & ~bit_mask);
            wr_en    = 1'b1;
         end
         lmcf_pkg::JOB_ROW: begin
            new_byte = job_ff.value;
            wr_en    = 1'b1;
         end
         lmcf_pkg::JOB_CLEAR: begin
            new_byte = '0;
            wr_en    = 1'b1;
         end
         default: begin
            new_byte = job_ff.value;
            opc_in   = job_ff.reg_opc;
         end
      endcase
      data_in = new_byte;
      wr_en   = wr_en && (state_ff == ST_MODIFY);
   end

   // Shadow memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= new_byte;
      end
      rd_data_ff <= mem[addr];
   end

   // Rows never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[addr] <= 1'b1;
      end
   end

   // Sequence frames and drive the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_out_ff <= 1'b0;
      end else begin
         if (out_free) begin
            valid_out_ff <= (state_ff == ST_EMIT);
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_status.empty) begin
                  job_ff   <= head_job;
                  row_ff   <= ((head_job.op == lmcf_pkg::JOB_COLUMN) ||
                               (head_job.op == lmcf_pkg::JOB_CLEAR)) ? '0 : head_job.row;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: state_ff <= ST_MODIFY;
            ST_MODIFY: begin
               opc_ff   <= opc_in;
               data_ff  <= data_in;
               idx_ff   <= lmcf_pkg::DEV_W'(eff_count - 1'b1);
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) begin
                  word_ff  <= (idx_ff == job_ff.device) ? {4'b0, opc_ff, data_ff} : '0;
                  eof_ff   <= (idx_ff == '0);
                  last_ff  <= (idx_ff == '0) && final_frame;
                  if (idx_ff != '0) begin
                     idx_ff <= idx_ff - 1'b1;
                  end else if (final_frame) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     row_ff   <= row_ff + 1'b1;
                     state_ff <= ST_READ;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_word         = word_ff;
   assign rsp_end_of_frame = eof_ff;
   assign rsp_last         = last_ff;
   assign rsp_valid        = valid_out_ff;

endmodule

/* rtl/core/led_matrix_chain_command_framer_top.sv */
// Framer for a daisy chain of 8x8 LED matrix controllers: sends each command
// as frames of one 16-bit word per device, farthest device first, and keeps a
// shadow byte per row. Each frame reads the row's shadow byte, updates it and
// then sends one word per device, held while rsp_stall is high; set column and
// clear send eight frames, one per row, and other commands one frame. The single
// shadow memory port and the one output register set the pace of these steps.
// Commands queue two deep ahead of the frame sequencer. Rows read as zero
// after reset with no clearing pass. The device count register sits at byte
// address 0 and must be written only while the block is idle.
// Depends on lmcf_pkg, lmcf_front, lmcf_queue and lmcf_back.
module led_matrix_chain_command_framer_top #(
   parameter int MAX_DEVICES = lmcf_pkg::MAX_DEVICES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [lmcf_pkg::KIND_W-1:0]  req_kind,
   input  logic [lmcf_pkg::DEV_W-1:0]   req_device,
   input  logic [lmcf_pkg::ROW_W-1:0]   req_row,
   input  logic [lmcf_pkg::COL_W-1:0]   req_column,
   input  logic [lmcf_pkg::VAL_W-1:0]   req_value,
   input  logic [lmcf_pkg::OPC_W-1:0]   req_opcode,
   input  logic                         req_valid,
   output logic                         req_stall,
   output logic [lmcf_pkg::WORD_W-1:0]  rsp_word,
   output logic                         rsp_end_of_frame,
   output logic                         rsp_last,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [lmcf_pkg::PADDR_W-1:0] paddr,
   input  logic [lmcf_pkg::PDATA_W-1:0] pwdata,
   output logic [lmcf_pkg::PDATA_W-1:0] prdata,
   output logic                         pready
);

   logic [lmcf_pkg::CNT_W-1:0] count_ff;
   logic [lmcf_pkg::CNT_W-1:0] eff_count;
   logic q_push, q_pop;
   lmcf_pkg::job_type q_in_job, q_head_job;
   lmcf_pkg::queue_status_type q_status;

   // Register port: word aligned, one register
   assign pready = 1'b1;
   assign prdata = (paddr[2] == lmcf_pkg::REG_DEVICE_COUNT) ?
                   lmcf_pkg::PDATA_W'(count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= lmcf_pkg::COUNT_RESET;
      end else if (psel && penable && pwrite && pready &&
                   (paddr[2] == lmcf_pkg::REG_DEVICE_COUNT)) begin
         count_ff <= pwdata[lmcf_pkg::CNT_W-1:0];
      end
   end

   // Out-of-range counts act as the full chain
   assign eff_count = ((count_ff == '0) || (count_ff > lmcf_pkg::CNT_W'(MAX_DEVICES))) ?
                      lmcf_pkg::CNT_W'(MAX_DEVICES) : count_ff;

   lmcf_front u_front (
      .req_kind   (req_kind),
      .req_device (req_device),
      .req_row    (req_row),
      .req_column (req_column),
      .req_value  (req_value),
      .req_opcode (req_opcode),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .eff_count  (eff_count),
      .q_status   (q_status),
      .push       (q_push),
      .job        (q_in_job)
   );

   lmcf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_in_job),
      .pop      (q_pop),
      .head_job (q_head_job),
      .status   (q_status)
   );

   lmcf_back #(
      .MAX_DEVICES (MAX_DEVICES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .eff_count        (eff_count),
      .q_status         (q_status),
      .head_job         (q_head_job),
      .pop              (q_pop),
      .rsp_word         (rsp_word),
      .rsp_end_of_frame (rsp_end_of_frame),
      .rsp_last         (rsp_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall)
   );

`ifndef NO_ASSERTIONS
   // The final word of a command always closes a frame
   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_end_of_frame)
      else $error("last word is not at end of frame");

   // Words within a frame follow without a gap
   a_frame_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_end_of_frame |=> rsp_valid)
      else $error("gap inside a frame");

   // The front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("push into full queue");
`endif

endmodule
